@@ src/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants of the positional list unit
// Operation and status codes, field widths and the command that the list
// control hands to every storage cell.
// ----------------------------------------------------------------------------
package pli_pkg;

	// Field widths of the stream words.
	localparam int MODE_W   = 2;
	localparam int POS_W    = 5;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;
	localparam int IN_DW    = 40;
	localparam int OUT_DW   = 40;

	// Default number of list entries.
	localparam int DEPTH_DEF = 16;

	// Operation codes carried in the mode field.
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_ERASE  = 2'd1,
		MODE_READ   = 2'd2
	} mode_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Command broadcast to the row of cells for one accepted word.
	typedef struct packed {
		logic             ins;
		logic             era;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

endpackage

@@ src/positional_list_insert_erase_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_insert_erase_unit: packed list with insert, erase and read
// A row of cells holds the list at positions 0 to count-1. Insert and erase
// move all cells at and above the position at once; read picks the addressed cell.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  s_axis    in         mode, position, value
//  m_axis    out        read_value, count, status
//
//  One word is taken per cycle unless a stalled result word holds it off, and its
//  result word appears in the output register on the next cycle; the shift of all
//  cells and the read of the addressed cell both finish in the cycle of acceptance.
//  Reset clears the entry count and the output valid flag; cell contents stay
//  undefined until written.
//  A stalled result word holds s_axis_tready low until it is taken.
// ----------------------------------------------------------------------------
module positional_list_insert_erase_unit #(
	parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// [1:0] mode, [6:2] position, [38:7] value, [39] zero
	input  logic [pli_pkg::IN_DW-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [31:0] read_value, [36:32] count, [38:37] status, [39] zero
	output logic [pli_pkg::OUT_DW-1:0] m_axis_tdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > pli_pkg::POS_W) ? CNT_W : pli_pkg::POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [pli_pkg::MODE_W-1:0] mode;
	logic [pli_pkg::POS_W-1:0]  position;
	logic [pli_pkg::VAL_W-1:0]  value;
	logic                       acc;

	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           count_d;
	logic [CMP_W-1:0]           pos_x;
	logic [CMP_W-1:0]           cnt_x;
	logic [CMP_W-1:0]           cnt_new_x;
	pli_pkg::status_t           st_d;
	logic                       ins_ok;
	logic                       era_ok;
	logic                       rd_ok;
	pli_pkg::cell_cmd_t         cmd;

	logic [pli_pkg::VAL_W-1:0]  cell_data [DEPTH];
	logic [pli_pkg::VAL_W-1:0]  cell_rd   [DEPTH];
	logic [pli_pkg::VAL_W-1:0]  rd_bus;

	logic                       out_valid_q;
	logic [pli_pkg::VAL_W-1:0]  read_value_q;
	logic [pli_pkg::POS_W-1:0]  count_out_q;
	pli_pkg::status_t           status_q;

	// Unpack the input word.
	assign mode     = s_axis_tdata[1:0];
	assign position = s_axis_tdata[6:2];
	assign value    = s_axis_tdata[38:7];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(count_q);

	// Check the operation against the count and work out the new count.
	always_comb begin
		st_d    = pli_pkg::ST_OK;
		ins_ok  = 1'b0;
		era_ok  = 1'b0;
		rd_ok   = 1'b0;
		count_d = count_q;
		case (mode)
			pli_pkg::MODE_INSERT: begin
				if (count_q == FULL_CNT) begin
					st_d = pli_pkg::ST_FULL;
				end else if (pos_x > cnt_x) begin
					st_d = pli_pkg::ST_RANGE;
				end else begin
					ins_ok  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			pli_pkg::MODE_ERASE: begin
				if (count_q == '0) begin
					st_d = pli_pkg::ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					st_d = pli_pkg::ST_RANGE;
				end else begin
					era_ok  = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			pli_pkg::MODE_READ: begin
				if (count_q == '0) begin
					st_d = pli_pkg::ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					st_d = pli_pkg::ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cnt_new_x = CMP_W'(count_d);

	// Command to the cells: only a successful, accepted shift moves data.
	assign cmd.ins = acc && ins_ok;
	assign cmd.era = acc && era_ok;
	assign cmd.pos = position;

	// Row of storage cells, each linked to its neighbors; the first takes the input value from below, the last itself.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [pli_pkg::VAL_W-1:0] left_w;
		logic [pli_pkg::VAL_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		pli_cell #(
			.IDX   (i),
			.DEPTH (DEPTH)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.value (value),
			.data  (cell_data[i]),
			.rd    (cell_rd[i])
		);
	end

	// Only the addressed cell drives a nonzero word, so an OR picks it.
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_d;
		end
	end

	// Output register: valid flag under reset, payload loaded on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			read_value_q <= rd_ok ? rd_bus : '0;
			count_out_q  <= cnt_new_x[pli_pkg::POS_W-1:0];
			status_q     <= st_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, status_q, count_out_q, read_value_q};

	// The list never holds more entries than there are cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	// A full status is only reported with every cell in use.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == pli_pkg::ST_FULL |-> count_q == FULL_CNT)
		else $error("full status with free cells");

	// An empty status is only reported on an empty list.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == pli_pkg::ST_EMPTY |-> count_q == '0)
		else $error("empty status with entries present");

	// A successful insert grows the list by one.
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the list");

	// While a result stalls, the list does not change.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> $stable(count_q))
		else $error("count changed during output stall");

endmodule

@@ src/pli_cell.sv @@
// ----------------------------------------------------------------------------
// pli_cell: one storage cell of the positional list
// Holds the entry at a fixed list index and moves it to or from its
// neighbors when an insert or erase shifts the list.
// ----------------------------------------------------------------------------
module pli_cell #(
	parameter int IDX   = 0,
	parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  pli_pkg::cell_cmd_t        cmd,
	input  logic [pli_pkg::VAL_W-1:0] left,   // entry of the cell one index below
	input  logic [pli_pkg::VAL_W-1:0] right,  // entry of the cell one index above
	input  logic [pli_pkg::VAL_W-1:0] value,  // entry to insert
	output logic [pli_pkg::VAL_W-1:0] data,
	output logic [pli_pkg::VAL_W-1:0] rd
);

	localparam int IX_W = (pli_pkg::POS_W > $clog2(DEPTH) + 1) ?
		pli_pkg::POS_W : $clog2(DEPTH) + 1;
	localparam logic [IX_W-1:0] MY_IDX = IX_W'(IDX);

	logic [pli_pkg::VAL_W-1:0] data_q;
	logic [IX_W-1:0]           pos_x;

	assign pos_x = IX_W'(cmd.pos);

	// Shift up above the insert point, load at it; shift down from the erase point.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX > pos_x) begin
				data_q <= left;
			end else if (MY_IDX == pos_x) begin
				data_q <= value;
			end
		end else if (cmd.era) begin
			if (MY_IDX >= pos_x) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;

	// The addressed cell drives its entry onto the read OR bus.
	assign rd = (MY_IDX == pos_x) ? data_q : '0;

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the positional list insert and erase unit
// Words of mode, position and value go in on the s_axis side. Each accepted
// word is also run through an in-bench list model, and the result word it
// predicts is queued. Result words on the m_axis side are checked field by
// field against the oldest queued prediction. A short table of directed words
// covers the empty and full list, out-of-range positions, the unused mode and
// the value extremes. Random words follow, biased to sweep the list between
// empty and full, under three settings of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH    = 16;
	localparam int WORDS_PER_RUN = 640;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int N_ROWS        = 22;

	// Field widths and codes taken from the shared package.
	localparam int MODE_W = pli_pkg::MODE_W;
	localparam int POS_W  = pli_pkg::POS_W;
	localparam int VAL_W  = pli_pkg::VAL_W;
	localparam int IN_DW  = pli_pkg::IN_DW;
	localparam int OUT_DW = pli_pkg::OUT_DW;

	localparam logic [MODE_W-1:0] MODE_INSERT = pli_pkg::MODE_INSERT;
	localparam logic [MODE_W-1:0] MODE_ERASE  = pli_pkg::MODE_ERASE;
	localparam logic [MODE_W-1:0] MODE_READ   = pli_pkg::MODE_READ;

	localparam pli_pkg::status_t ST_OK    = pli_pkg::ST_OK;
	localparam pli_pkg::status_t ST_RANGE = pli_pkg::ST_RANGE;
	localparam pli_pkg::status_t ST_FULL  = pli_pkg::ST_FULL;
	localparam pli_pkg::status_t ST_EMPTY = pli_pkg::ST_EMPTY;

	// Mode code that the block ignores.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// One result word.
	typedef struct packed {
		logic [VAL_W-1:0]  read_value;
		logic [POS_W-1:0]  count;
		pli_pkg::status_t  status;
	} list_result_t;

	// One row of the directed table; a row with reps above one repeats its
	// word with the value stepped by one each time.
	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [POS_W-1:0]  at;
		logic [VAL_W-1:0]  val;
		logic [POS_W-1:0]  reps;
		bit                typed;
		list_result_t      want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DW-1:0] m_axis_tdata;

	// List model state.
	logic [VAL_W-1:0] list_mem [LIST_DEPTH];
	int unsigned list_len = 0;

	list_result_t pending_results [$];
	int mismatch_cnt = 0;
	int words_sent = 0;
	int results_seen = 0;
	int status_tally [4] = '{0, 0, 0, 0};
	int src_idle = 0;
	int dst_stall = 0;
	int quiet_cycles = 0;
	bit fill_up = 1'b1;

	dir_row_t dir_rows [N_ROWS] = '{
		'{MODE_READ,   5'd0,  32'd0,          5'd1,  1'b1, '{32'd0, 5'd0, ST_EMPTY}},
		'{MODE_ERASE,  5'd0,  32'd0,          5'd1,  1'b1, '{32'd0, 5'd0, ST_EMPTY}},
		'{MODE_INSERT, 5'd1,  32'h1234_5678,  5'd1,  1'b1, '{32'd0, 5'd0, ST_RANGE}},
		'{MODE_INSERT, 5'd0,  32'h7fff_ffff,  5'd1,  1'b1, '{32'd0, 5'd1, ST_OK}},
		'{MODE_INSERT, 5'd0,  32'h8000_0000,  5'd1,  1'b1, '{32'd0, 5'd2, ST_OK}},
		'{MODE_READ,   5'd0,  32'd0,          5'd1,  1'b1, '{32'h8000_0000, 5'd2, ST_OK}},
		'{MODE_READ,   5'd1,  32'hffff_ffff,  5'd1,  1'b1, '{32'h7fff_ffff, 5'd2, ST_OK}},
		'{MODE_READ,   5'd2,  32'd0,          5'd1,  1'b1, '{32'd0, 5'd2, ST_RANGE}},
		'{MODE_ERASE,  5'd31, 32'd0,          5'd1,  1'b1, '{32'd0, 5'd2, ST_RANGE}},
		'{MODE_UNUSED, 5'd31, 32'hffff_ffff,  5'd1,  1'b1, '{32'd0, 5'd2, ST_OK}},
		'{MODE_INSERT, 5'd2,  32'hffff_ffff,  5'd1,  1'b0, '0},
		'{MODE_INSERT, 5'd1,  32'h0000_1000,  5'd13, 1'b0, '0},
		'{MODE_INSERT, 5'd0,  32'h5555_5555,  5'd1,  1'b1, '{32'd0, 5'd16, ST_FULL}},
		'{MODE_INSERT, 5'd31, 32'haaaa_aaaa,  5'd1,  1'b1, '{32'd0, 5'd16, ST_FULL}},
		'{MODE_READ,   5'd15, 32'd0,          5'd1,  1'b0, '0},
		'{MODE_READ,   5'd16, 32'd0,          5'd1,  1'b1, '{32'd0, 5'd16, ST_RANGE}},
		'{MODE_READ,   5'd31, 32'd0,          5'd1,  1'b1, '{32'd0, 5'd16, ST_RANGE}},
		'{MODE_ERASE,  5'd15, 32'd0,          5'd1,  1'b0, '0},
		'{MODE_ERASE,  5'd0,  32'd0,          5'd1,  1'b0, '0},
		'{MODE_INSERT, 5'd14, 32'd0,          5'd1,  1'b0, '0},
		'{MODE_INSERT, 5'd16, 32'd7,          5'd1,  1'b1, '{32'd0, 5'd15, ST_RANGE}},
		'{MODE_UNUSED, 5'd0,  32'd0,          5'd1,  1'b1, '{32'd0, 5'd15, ST_OK}}
	};

	positional_list_insert_erase_unit #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one word to the list model and return the result it yields.
	// A failed operation leaves the list as it was.
	function automatic list_result_t list_apply(logic [MODE_W-1:0] op,
			logic [POS_W-1:0] at, logic [VAL_W-1:0] val);
		list_result_t res;
		int i;
		res.read_value = '0;
		res.status = ST_OK;
		case (op)
			MODE_INSERT: begin
				if (list_len >= LIST_DEPTH) begin
					res.status = ST_FULL;
				end else if (at > list_len) begin
					res.status = ST_RANGE;
				end else begin
					for (i = list_len; i > at; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[at] = val;
					list_len++;
				end
			end
			MODE_ERASE: begin
				if (list_len == 0) begin
					res.status = ST_EMPTY;
				end else if (at >= list_len) begin
					res.status = ST_RANGE;
				end else begin
					for (i = at + 1; i < list_len; i++)
						list_mem[i-1] = list_mem[i];
					list_len--;
				end
			end
			MODE_READ: begin
				if (list_len == 0) begin
					res.status = ST_EMPTY;
				end else if (at >= list_len) begin
					res.status = ST_RANGE;
				end else begin
					res.read_value = list_mem[at];
				end
			end
			default: begin
				// The unused mode changes nothing.
			end
		endcase
		res.count = list_len[POS_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
			logic [VAL_W-1:0] want);
		$display("%0t: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// Offer one word, with random idle cycles ahead of it, and queue its
	// predicted result once accepted. A typed result replaces the prediction.
	task automatic send_word(logic [MODE_W-1:0] op, logic [POS_W-1:0] at,
			logic [VAL_W-1:0] val, bit typed, list_result_t want);
		list_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, val, at, op};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		res = list_apply(op, at, val);
		status_tally[res.status]++;
		words_sent++;
		pending_results.push_back(typed ? want : res);
	endtask

	// Drop valid and hold off until every queued result has arrived.
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver stalls.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= dst_stall);

	// Check each accepted result word against the oldest prediction.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result word with none expected",
					m_axis_tdata[31:0], '0);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== want.read_value)
					report_mismatch("read_value", m_axis_tdata[31:0], want.read_value);
				if (m_axis_tdata[36:32] !== want.count)
					report_mismatch("count", 32'(m_axis_tdata[36:32]), 32'(want.count));
				if (m_axis_tdata[38:37] !== want.status)
					report_mismatch("status", 32'(m_axis_tdata[38:37]),
						32'(want.status));
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Timeout after %0d quiet cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [MODE_W-1:0] op;
		logic [POS_W-1:0] at;
		int r;
		int k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table.
		src_idle = 6;
		dst_stall = 57;
		foreach (dir_rows[i]) begin
			for (k = 0; k < dir_rows[i].reps; k++)
				send_word(dir_rows[i].op, dir_rows[i].at, dir_rows[i].val + k,
					dir_rows[i].typed, dir_rows[i].want);
		end
		drain_results();

		// Random words in three idling settings; the list drifts toward full
		// or toward empty and turns at either end.
		for (int run = 0; run < 3; run++) begin
			src_idle = (run == 0) ? 6 : (run == 1) ? 57 : 0;
			dst_stall = (run == 0) ? 57 : (run == 1) ? 6 : 0;
			repeat (WORDS_PER_RUN) begin
				if (list_len == LIST_DEPTH)
					fill_up = 1'b0;
				else if (list_len == 0)
					fill_up = 1'b1;
				else if ($urandom_range(99) < 5)
					fill_up = !fill_up;
				r = $urandom_range(99);
				if (r < 3)
					op = MODE_UNUSED;
				else if (r < 23)
					op = MODE_READ;
				else if ((r < 73) == fill_up)
					op = MODE_INSERT;
				else
					op = MODE_ERASE;
				if ($urandom_range(9) == 0)
					at = POS_W'($urandom_range(31));
				else if (op == MODE_INSERT)
					at = POS_W'($urandom_range(list_len));
				else
					at = (list_len == 0) ? '0 : POS_W'($urandom_range(list_len - 1));
				send_word(op, at, $urandom, 1'b0, '0);
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results still expected", pending_results.size(), 0);
		$display("Sent %0d words and checked %0d result words.", words_sent, results_seen);
		$display("Status ok/range/full/empty: %0d/%0d/%0d/%0d.",
			status_tally[ST_OK], status_tally[ST_RANGE],
			status_tally[ST_FULL], status_tally[ST_EMPTY]);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
